// ===== src/snooping_lru_cache_vi_defines.svh =====
// ---------------------------------------------------------------------------
// Snooping LRU cache assertion macros
// Shared assertion forms used by the cache RTL.
// ---------------------------------------------------------------------------
`ifndef SNOOPING_LRU_CACHE_VI_DEFINES_SVH
`define SNOOPING_LRU_CACHE_VI_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SLC_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SLC_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ===== src/slc_pkg.sv =====
// ---------------------------------------------------------------------------
// Snooping LRU cache package
// Geometry constants, operation codes and shared types.
// ---------------------------------------------------------------------------
package slc_pkg;
  localparam int WAYS        = 8;
  localparam int LINE_BYTES  = 32;
  localparam int TOTAL_BYTES = 32768;
  localparam int ADDR_BITS   = 32;
  localparam int SETS        = TOTAL_BYTES / (LINE_BYTES * WAYS);
  localparam int WORDS       = LINE_BYTES / 4;
  localparam int OFF_W       = $clog2(LINE_BYTES);
  localparam int SET_W       = $clog2(SETS);
  localparam int WORD_W      = $clog2(WORDS);
  localparam int WAY_W       = $clog2(WAYS);
  localparam int TAG_W       = ADDR_BITS - OFF_W - SET_W;
  localparam int LOW_W       = $clog2(TOTAL_BYTES);

  typedef enum logic [1:0] {
    OP_CPU_RD = 2'd0, OP_CPU_WR = 2'd1, OP_SNP_RD = 2'd2, OP_SNP_WR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DONE_RD = 2'd0, DONE_WR = 2'd1, DONE_NONE = 2'd2
  } done_t;

  typedef enum logic [1:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP
  } state_t;

  // Classified transaction passed from the front to the back.
  typedef struct packed {
    logic              cpu;
    logic              wr;
    logic              skip;
    logic              low;
    logic [TAG_W-1:0]  tag;
    logic [SET_W-1:0]  set;
    logic [WORD_W-1:0] word;
    logic [31:0]       wdata;
    logic [31:0]       fdata;
  } cmd_t;
endpackage

// ===== src/snooping_lru_cache_vi.sv =====
// ---------------------------------------------------------------------------
// Snooping LRU cache top level
// 8-way, 128-set write-invalidate snooping cache with LRU replacement.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 1024 word rows, one word
// row a cycle (the set rows are cleared along with it), before it takes its
// first transaction. In the back end each transaction first reads the set row
// and word row from synchronous memory, then resolves and writes back; it waits
// in lookup while the result register is full and stalled, and the next one is
// taken only after that. A two-entry queue lets the front accept transactions
// while the back end or the result side stalls.
module snooping_lru_cache_vi (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_own_id,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_address,
  input  logic signed [31:0] in_write_data,
  input  logic signed [31:0] in_fill_data,
  input  logic [2:0]         in_requester_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_read_data,
  output logic               out_data_valid,
  output logic               out_bus_read_request,
  output logic               out_bus_write_request,
  output logic [1:0]         out_done_code
);
  import slc_pkg::*;

  logic [2:0] own_id_r;
  logic       q_valid, q_pop;
  cmd_t       q_cmd;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= 3'd0;
    end else if (cfg_valid) begin
      own_id_r <= cfg_own_id;
    end
  end

  slc_front u_front (
    .clk, .rst_n, .own_id(own_id_r), .in_valid, .in_stall, .in_op, .in_address,
    .in_write_data, .in_fill_data, .in_requester_id, .q_valid, .q_pop, .q_cmd
  );

  slc_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_stall, .out_hit,
    .out_read_data, .out_data_valid, .out_bus_read_request,
    .out_bus_write_request, .out_done_code
  );
endmodule

// ===== src/slc_front.sv =====
// ---------------------------------------------------------------------------
// Snooping LRU cache front end
// Accepts transactions, splits the address and queues classified commands.
// ---------------------------------------------------------------------------
module slc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          own_id,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_address,
  input  logic signed [31:0]  in_write_data,
  input  logic signed [31:0]  in_fill_data,
  input  logic [2:0]          in_requester_id,
  output logic                q_valid,
  input  logic                q_pop,
  output slc_pkg::cmd_t       q_cmd
);
  import slc_pkg::*;

  // Two-entry command queue.
  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd;
  logic       push;

  // Classify the incoming transaction.
  always_comb begin
    cmd.cpu   = (in_op == OP_CPU_RD) || (in_op == OP_CPU_WR);
    cmd.wr    = in_op[0];
    cmd.skip  = !cmd.cpu && (in_requester_id == own_id);
    cmd.low   = (in_address[31:LOW_W] == '0);
    cmd.word  = in_address[OFF_W-1:2];
    cmd.set   = in_address[OFF_W +: SET_W];
    cmd.tag   = in_address[ADDR_BITS-1 -: TAG_W];
    cmd.wdata = in_write_data;
    cmd.fdata = in_fill_data;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];

  // Pointer and count update.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
  end

  `include "snooping_lru_cache_vi_defines.svh"
  `SLC_ASSERT_IMPL(a_no_pop_empty, q_pop, cnt_r != 2'd0, "pop from empty queue")
  `SLC_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r != 2'd3, "queue count overflow")
  `SLC_ASSERT_NEXT(a_full_push, push && !q_pop && cnt_r == 2'd1, cnt_r == 2'd2,
                   "queue count lost a push")
endmodule

// ===== src/slc_back.sv =====
// ---------------------------------------------------------------------------
// Snooping LRU cache back end
// Reads a set, resolves hit and victim, writes back and posts the result.
// ---------------------------------------------------------------------------
module slc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  slc_pkg::cmd_t       q_cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic signed [31:0]  out_read_data,
  output logic                out_data_valid,
  output logic                out_bus_read_request,
  output logic                out_bus_write_request,
  output logic [1:0]          out_done_code
);
  import slc_pkg::*;

  localparam int LINE_W = 1 + TAG_W + WAY_W;
  localparam int CLR_W  = SET_W + WORD_W;
  typedef logic [WAYS*LINE_W-1:0] row_t;
  typedef logic [WAYS*32-1:0] wrow_t;

  // Set memory: per way valid, tag, age. Word memory: one row holds the word
  // of every way for one set and word index.
  row_t        row_mem [SETS];
  wrow_t       word_mem [SETS*WORDS];

  state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  cmd_t cmd_r;
  row_t row_q;
  wrow_t wrow_q;
  logic out_full_r;
  logic hit_r, dv_r, brd_r, bwr_r;
  logic [31:0] rd_r;
  logic [1:0] done_r;

  logic out_free, start, finish;
  logic [WAYS-1:0] vld, match;
  logic [TAG_W-1:0] tg [WAYS];
  logic [WAY_W-1:0] ag [WAYS];
  logic hit;
  logic [WAY_W-1:0] hway, vway, way;
  row_t row_new;
  wrow_t wrow_new;
  logic row_we, word_we;
  logic [31:0] word_wd, rdata;
  logic dv, brd, bwr;
  logic [1:0] done;

  assign out_free = !out_full_r || !out_stall;
  assign start    = (state_r == ST_IDLE) && q_valid;
  assign finish   = (state_r == ST_LOOKUP) && out_free;
  assign q_pop    = finish;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_W'(SETS * WORDS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE:   if (q_valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Unpack the row and search for hit and victim.
  always_comb begin
    hway = '0;
    vway = '0;
    hit = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      vld[i]   = row_q[i*LINE_W + TAG_W + WAY_W];
      tg[i]    = row_q[i*LINE_W + WAY_W +: TAG_W];
      ag[i]    = row_q[i*LINE_W +: WAY_W];
      match[i] = vld[i] && (tg[i] == cmd_r.tag);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = 1'b1;
        hway = WAY_W'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (ag[i] == WAY_W'(WAYS - 1)) vway = WAY_W'(i);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!vld[i]) begin
        vway = WAY_W'(i);
      end
    end
    way = hit ? hway : vway;
  end

  // Outputs and write-back for the item in lookup.
  always_comb begin
    logic touch, install;
    logic [WAY_W-1:0] prev;
    touch   = 1'b0;
    install = 1'b0;
    word_we = 1'b0;
    word_wd = cmd_r.wdata;
    rdata   = '0;
    dv = 1'b0; brd = 1'b0; bwr = 1'b0;
    done = DONE_NONE;
    row_new = row_q;
    if (cmd_r.cpu) begin
      touch = 1'b1;
      install = !hit;
      if (!cmd_r.wr) begin
        done = DONE_RD;
        dv = 1'b1;
        if (hit) begin
          rdata = wrow_q[way*32 +: 32];
        end else begin
          brd = 1'b1;
          word_we = 1'b1;
          word_wd = cmd_r.fdata;
          rdata = cmd_r.fdata;
        end
      end else begin
        done = DONE_WR;
        word_we = 1'b1;
        bwr = !hit;
      end
    end else if (!cmd_r.skip && hit) begin
      if (!cmd_r.wr) begin
        touch = 1'b1;
        dv = 1'b1;
        rdata = wrow_q[way*32 +: 32];
      end else begin
        row_new[way*LINE_W + TAG_W + WAY_W] = 1'b0;
      end
    end
    if (!cmd_r.low) rdata = '0;
    prev = ag[way];
    if (touch) begin
      for (int i = 0; i < WAYS; i++) begin
        if (ag[i] < prev) row_new[i*LINE_W +: WAY_W] = ag[i] + 1'b1;
      end
      row_new[way*LINE_W +: WAY_W] = '0;
    end
    if (install) begin
      row_new[way*LINE_W + TAG_W + WAY_W] = 1'b1;
      row_new[way*LINE_W + WAY_W +: TAG_W] = cmd_r.tag;
    end
    // The word row is written back whole with the one word replaced.
    wrow_new = wrow_q;
    wrow_new[way*32 +: 32] = word_wd;
    row_we = finish;
    word_we = word_we && finish;
  end

  // Set memory: clearing pass, lookup read and write-back.
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      for (int i = 0; i < WAYS; i++) begin
        row_mem[clr_r[CLR_W-1 -: SET_W]][i*LINE_W +: LINE_W] <=
          {1'b0, {TAG_W{1'b0}}, WAY_W'(i)};
      end
    end else if (row_we) begin
      row_mem[cmd_r.set] <= row_new;
    end
    if (start) row_q <= row_mem[q_cmd.set];
  end

  // Word memory: clearing pass, one row read and one row write.
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      word_mem[clr_r] <= '0;
    end else if (word_we) begin
      word_mem[{cmd_r.set, cmd_r.word}] <= wrow_new;
    end
    if (start) wrow_q <= word_mem[{q_cmd.set, q_cmd.word}];
  end

  always_ff @(posedge clk) begin
    if (start) cmd_r <= q_cmd;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (finish) begin
      out_full_r <= 1'b1;
    end else if (!out_stall) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit_r  <= hit && !(cmd_r.skip);
      rd_r   <= rdata;
      dv_r   <= dv;
      brd_r  <= brd;
      bwr_r  <= bwr;
      done_r <= done;
    end
  end

  assign out_valid             = out_full_r;
  assign out_hit               = hit_r;
  assign out_read_data         = rd_r;
  assign out_data_valid        = dv_r;
  assign out_bus_read_request  = brd_r;
  assign out_bus_write_request = bwr_r;
  assign out_done_code         = done_r;

  `include "snooping_lru_cache_vi_defines.svh"
  `SLC_ASSERT_IMPL(a_no_pop_clear, state_r == ST_CLEAR, !q_pop, "pop during clear")
  `SLC_ASSERT_NEXT(a_finish_out, finish, out_full_r, "result not posted")
  `SLC_ASSERT_IMPL(a_req_cpu, out_valid && (out_bus_read_request || out_bus_write_request),
                   out_done_code != DONE_NONE, "bus request on snoop")
endmodule
